>>> hw/rtl/kwl_pkg.sv
`timescale 1ns / 1ps

package kwl_pkg;

  localparam int KwCount = 7;

  // token kinds
  localparam logic [4:0] KIND_ILLEGAL   = 5'd0;
  localparam logic [4:0] KIND_EOF       = 5'd1;
  localparam logic [4:0] KIND_IDENT     = 5'd2;
  localparam logic [4:0] KIND_INT       = 5'd3;
  localparam logic [4:0] KIND_ASSIGN    = 5'd4;
  localparam logic [4:0] KIND_PLUS      = 5'd5;
  localparam logic [4:0] KIND_MINUS     = 5'd6;
  localparam logic [4:0] KIND_BANG      = 5'd7;
  localparam logic [4:0] KIND_ASTERISK  = 5'd8;
  localparam logic [4:0] KIND_SLASH     = 5'd9;
  localparam logic [4:0] KIND_LT        = 5'd10;
  localparam logic [4:0] KIND_GT        = 5'd11;
  localparam logic [4:0] KIND_EQ        = 5'd12;
  localparam logic [4:0] KIND_NOT_EQ    = 5'd13;
  localparam logic [4:0] KIND_COMMA     = 5'd14;
  localparam logic [4:0] KIND_SEMICOLON = 5'd15;
  localparam logic [4:0] KIND_LPAREN    = 5'd16;
  localparam logic [4:0] KIND_RPAREN    = 5'd17;
  localparam logic [4:0] KIND_LBRACE    = 5'd18;
  localparam logic [4:0] KIND_RBRACE    = 5'd19;
  localparam logic [4:0] KIND_KEYWORD0  = 5'd20;

  // pending token codes
  localparam logic [2:0] PEND_NONE   = 3'd0;
  localparam logic [2:0] PEND_IDENT  = 3'd1;
  localparam logic [2:0] PEND_INT    = 3'd2;
  localparam logic [2:0] PEND_ASSIGN = 3'd3;
  localparam logic [2:0] PEND_BANG   = 3'd4;

  localparam logic [6:0] ALL_KEYWORDS = 7'h7F;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  // up to two tokens produced by one source byte, first one first
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } tok_pair_t;

  typedef struct packed {
    logic       is_zero;
    logic       is_blank;
    logic       is_alpha;
    logic       is_num;
    logic       is_eq;
    logic       is_bang;
    logic [4:0] punct;
  } char_class_t;

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] len;
    unique case (k)
      3'd0:    len = 3'd2;
      3'd1:    len = 3'd3;
      3'd2:    len = 3'd4;
      3'd3:    len = 3'd5;
      3'd4:    len = 3'd2;
      3'd5:    len = 3'd4;
      3'd6:    len = 3'd6;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // character of keyword k at position pos, zero past its end
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
    logic [47:0] txt;
    logic [47:0] sh;
    unique case (k)
      3'd0:    txt = {"fn", 32'h0};
      3'd1:    txt = {"let", 24'h0};
      3'd2:    txt = {"true", 16'h0};
      3'd3:    txt = {"false", 8'h0};
      3'd4:    txt = {"if", 32'h0};
      3'd5:    txt = {"else", 16'h0};
      3'd6:    txt = "return";
      default: txt = '0;
    endcase
    sh = txt << {pos, 3'b000};
    return sh[47:40];
  endfunction

  // drop every keyword without character c at position pos, all if pos_ok is low
  function automatic logic [6:0] kw_narrow(input logic [6:0] mask, input logic pos_ok,
                                           input logic [2:0] pos, input logic [7:0] c);
    logic [6:0] res;
    res = mask;
    for (int k = 0; k < KwCount; k++) begin
      if (!(pos_ok && (pos < kw_len(3'(k))) && (kw_char(3'(k), pos) == c))) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

  // lowest-numbered surviving keyword of matching length, else identifier
  function automatic logic [4:0] ident_kind(input logic [6:0] mask, input logic len_ok,
                                            input logic [2:0] len3);
    logic [4:0] kind;
    kind = KIND_IDENT;
    for (int k = KwCount - 1; k >= 0; k--) begin
      if (mask[k] && len_ok && (len3 == kw_len(3'(k)))) begin
        kind = KIND_KEYWORD0 + 5'(k);
      end
    end
    return kind;
  endfunction

endpackage

>>> hw/rtl/kwl_classify.sv
`timescale 1ns / 1ps

module kwl_classify (
  input  logic [7:0]           c,
  output kwl_pkg::char_class_t cls
);

  logic [4:0] punct;

  always_comb begin
    unique case (c)
      "+":     punct = kwl_pkg::KIND_PLUS;
      "-":     punct = kwl_pkg::KIND_MINUS;
      "*":     punct = kwl_pkg::KIND_ASTERISK;
      "/":     punct = kwl_pkg::KIND_SLASH;
      "<":     punct = kwl_pkg::KIND_LT;
      ">":     punct = kwl_pkg::KIND_GT;
      ",":     punct = kwl_pkg::KIND_COMMA;
      ";":     punct = kwl_pkg::KIND_SEMICOLON;
      "(":     punct = kwl_pkg::KIND_LPAREN;
      ")":     punct = kwl_pkg::KIND_RPAREN;
      "{":     punct = kwl_pkg::KIND_LBRACE;
      "}":     punct = kwl_pkg::KIND_RBRACE;
      default: punct = kwl_pkg::KIND_ILLEGAL;
    endcase
  end

  always_comb begin
    cls.is_zero  = (c == 8'h00);
    cls.is_blank = (c == " ") || (c == "\t") || (c == "\n") || (c == "\r");
    cls.is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    cls.is_num   = (c >= "0") && (c <= "9");
    cls.is_eq    = (c == "=");
    cls.is_bang  = (c == "!");
    cls.punct    = punct;
  end

endmodule

>>> hw/rtl/kwl_core.sv
`timescale 1ns / 1ps

module kwl_core #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [7:0]             c,
  input  kwl_pkg::char_class_t   cls,
  output kwl_pkg::tok_pair_t     pair
);

  logic [2:0]              pending_kind, pending_kind_next;
  logic [OFFSET_WIDTH-1:0] pending_start, pending_start_next;
  logic [OFFSET_WIDTH-1:0] pending_length, pending_length_next;
  logic [6:0]              keyword_candidates, keyword_candidates_next;
  logic [OFFSET_WIDTH-1:0] text_offset, text_offset_next;

  logic                    flush_valid, new_valid;
  kwl_pkg::tok_t           flush_tok, new_tok;
  logic [OFFSET_WIDTH-1:0] offset_inc, length_inc;
  logic                    pos_ok, len_ok;

  function automatic logic [OFFSET_WIDTH-1:0] sat_inc(input logic [OFFSET_WIDTH-1:0] v);
    return (&v) ? v : v + OFFSET_WIDTH'(1);
  endfunction

  function automatic logic [15:0] lo16(input logic [OFFSET_WIDTH-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  assign offset_inc = sat_inc(text_offset);
  assign length_inc = sat_inc(pending_length);
  assign pos_ok     = pending_length < OFFSET_WIDTH'(6);
  assign len_ok     = pending_length < OFFSET_WIDTH'(7);

  always_comb begin
    pending_kind_next       = pending_kind;
    pending_start_next      = pending_start;
    pending_length_next     = pending_length;
    keyword_candidates_next = keyword_candidates;
    text_offset_next        = text_offset;
    flush_valid             = 1'b0;
    flush_tok               = '0;
    new_valid               = 1'b0;
    new_tok                 = '0;

    if (fire) begin
      if ((pending_kind == kwl_pkg::PEND_IDENT) && cls.is_alpha) begin
        keyword_candidates_next = kwl_pkg::kw_narrow(keyword_candidates, pos_ok,
                                                     pending_length[2:0], c);
        pending_length_next     = length_inc;
        text_offset_next        = offset_inc;
      end else if ((pending_kind == kwl_pkg::PEND_INT) && cls.is_num) begin
        pending_length_next = length_inc;
        text_offset_next    = offset_inc;
      end else if (((pending_kind == kwl_pkg::PEND_ASSIGN) ||
                    (pending_kind == kwl_pkg::PEND_BANG)) && cls.is_eq) begin
        flush_valid         = 1'b1;
        flush_tok.kind      = (pending_kind == kwl_pkg::PEND_ASSIGN) ?
                              kwl_pkg::KIND_EQ : kwl_pkg::KIND_NOT_EQ;
        flush_tok.start     = lo16(pending_start);
        flush_tok.length    = 16'd2;
        pending_kind_next   = kwl_pkg::PEND_NONE;
        pending_length_next = '0;
        text_offset_next    = offset_inc;
      end else begin
        // the byte ends whatever is pending
        unique case (pending_kind)
          kwl_pkg::PEND_ASSIGN: begin
            flush_valid      = 1'b1;
            flush_tok.kind   = kwl_pkg::KIND_ASSIGN;
            flush_tok.length = 16'd1;
          end
          kwl_pkg::PEND_BANG: begin
            flush_valid      = 1'b1;
            flush_tok.kind   = kwl_pkg::KIND_BANG;
            flush_tok.length = 16'd1;
          end
          kwl_pkg::PEND_IDENT: begin
            flush_valid      = 1'b1;
            flush_tok.kind   = kwl_pkg::ident_kind(keyword_candidates, len_ok,
                                                   pending_length[2:0]);
            flush_tok.length = lo16(pending_length);
          end
          kwl_pkg::PEND_INT: begin
            flush_valid      = 1'b1;
            flush_tok.kind   = kwl_pkg::KIND_INT;
            flush_tok.length = lo16(pending_length);
          end
          default: flush_valid = 1'b0;
        endcase
        flush_tok.start         = lo16(pending_start);
        pending_kind_next       = kwl_pkg::PEND_NONE;
        pending_length_next     = '0;
        keyword_candidates_next = kwl_pkg::ALL_KEYWORDS;

        if (cls.is_zero) begin
          new_valid          = 1'b1;
          new_tok.kind       = kwl_pkg::KIND_EOF;
          new_tok.start      = lo16(text_offset);
          new_tok.length     = 16'd0;
          pending_start_next = '0;
          text_offset_next   = '0;
        end else begin
          if (cls.is_blank) begin
            // skipped
          end else if (cls.is_alpha) begin
            pending_kind_next       = kwl_pkg::PEND_IDENT;
            pending_start_next      = text_offset;
            pending_length_next     = OFFSET_WIDTH'(1);
            keyword_candidates_next = kwl_pkg::kw_narrow(kwl_pkg::ALL_KEYWORDS, 1'b1,
                                                         3'd0, c);
          end else if (cls.is_num) begin
            pending_kind_next   = kwl_pkg::PEND_INT;
            pending_start_next  = text_offset;
            pending_length_next = OFFSET_WIDTH'(1);
          end else if (cls.is_eq) begin
            pending_kind_next   = kwl_pkg::PEND_ASSIGN;
            pending_start_next  = text_offset;
            pending_length_next = OFFSET_WIDTH'(1);
          end else if (cls.is_bang) begin
            pending_kind_next   = kwl_pkg::PEND_BANG;
            pending_start_next  = text_offset;
            pending_length_next = OFFSET_WIDTH'(1);
          end else begin
            new_valid      = 1'b1;
            new_tok.kind   = cls.punct;
            new_tok.start  = lo16(text_offset);
            new_tok.length = 16'd1;
          end
          text_offset_next = offset_inc;
        end
      end
    end
  end

  // compact into first/second, mark the final token of the byte
  always_comb begin
    pair.count       = {1'b0, flush_valid} + {1'b0, new_valid};
    pair.first       = flush_valid ? flush_tok : new_tok;
    pair.first.last  = !(flush_valid && new_valid);
    pair.second      = new_tok;
    pair.second.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_kind       <= kwl_pkg::PEND_NONE;
      pending_start      <= '0;
      pending_length     <= '0;
      keyword_candidates <= kwl_pkg::ALL_KEYWORDS;
      text_offset        <= '0;
    end else begin
      pending_kind       <= pending_kind_next;
      pending_start      <= pending_start_next;
      pending_length     <= pending_length_next;
      keyword_candidates <= keyword_candidates_next;
      text_offset        <= text_offset_next;
    end
  end

endmodule

>>> hw/rtl/kwl_out_fifo.sv
`timescale 1ns / 1ps

module kwl_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  kwl_pkg::tok_pair_t pair,
  input  logic               pop_ready,
  output logic               pop_valid,
  output kwl_pkg::tok_t      head,
  output logic               room
);

  localparam int Depth = 4;

  kwl_pkg::tok_t mem [Depth];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign pop_valid = (count != 3'd0);
  assign pop       = pop_valid && pop_ready;
  assign head      = mem[rd_ptr];
  // space for the worst case of two tokens from one byte
  assign room      = (count <= 3'(Depth - 2));

  always_ff @(posedge clk) begin
    if (pair.count != 2'd0) begin
      mem[wr_ptr] <= pair.first;
    end
    if (pair.count == 2'd2) begin
      mem[wr_ptr + 2'd1] <= pair.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + pair.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, pair.count} - {2'b00, pop};
    end
  end

endmodule

>>> hw/rtl/keyword_token_lexer_top.sv
`timescale 1ns / 1ps
// Streaming lexer: one program-text byte per source transaction, tokens out
// as (token_kind, token_start, token_length, last_of_run) per token transaction.
// Source channel: source_valid/source_ready with source_byte; a zero byte
// ends the text, flushes any pending token, emits eof and restarts at offset 0.
// Token channel: token_valid/token_ready. A byte causes zero, one or two
// tokens; last_of_run marks the final token caused by that byte.
// A token is registered into the result queue when the byte that completes it
// is accepted. Identifiers, integers, '=' and '!' wait for the next byte.
// Throughput: one byte per cycle while source_ready is high. The lexer state
// is registered and tokens go into a four-entry result queue; source_ready is
// high while the queue has at least two free entries, so bytes that yield two
// tokens can hold the source off when the token side drains one per cycle.
// Stall: when token_ready is low the queue fills and source_ready drops;
// no token is lost or repeated.
// Reset (rst, synchronous): queue empty, no token pending, offset zero.
// OFFSET_WIDTH sets the internal offset/length counters, which saturate;
// the ports carry their low 16 bits.

module keyword_token_lexer_top #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        source_valid,
  output logic        source_ready,
  input  logic [7:0]  source_byte,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [4:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic        last_of_run
);

  kwl_pkg::char_class_t cls;
  kwl_pkg::tok_pair_t   pair;
  kwl_pkg::tok_t        head;
  logic                 room;
  logic                 fire;

  assign source_ready = room;
  assign fire         = source_valid && room;

  // byte classification
  kwl_classify u_classify (
    .c   (source_byte),
    .cls (cls)
  );

  // lexer state and token generation
  kwl_core #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .c    (source_byte),
    .cls  (cls),
    .pair (pair)
  );

  // result queue decouples the token receiver
  kwl_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .pair      (pair),
    .pop_ready (token_ready),
    .pop_valid (token_valid),
    .head      (head),
    .room      (room)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign last_of_run  = head.last;

  // end of text always produces at least the eof token
  a_eof_emits: assert property (@(posedge clk) disable iff (rst)
    (source_valid && source_ready && (source_byte == 8'h00)) |=> token_valid)
    else $error("zero byte accepted without a token");

  // an empty queue must be able to take a byte
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !token_valid |-> source_ready)
    else $error("source stalled with empty token queue");

  // nothing presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !token_valid)
    else $error("token presented after reset");

  // eof tokens carry no characters
  a_eof_len: assert property (@(posedge clk) disable iff (rst)
    (token_valid && (token_kind == kwl_pkg::KIND_EOF)) |-> (token_length == 16'd0))
    else $error("eof token with nonzero length");

endmodule
